[design/pulse_coupled_oscillator_sync_macros.svh]
// Assertion macros for the pulse-coupled oscillator sync block.
// Used by the port checker; depends on nothing else.
`ifndef PULSE_COUPLED_OSCILLATOR_SYNC_MACROS_SVH
`define PULSE_COUPLED_OSCILLATOR_SYNC_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PCOS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PCOS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pcos_pkg.sv]
// Shared types and constants of the pulse-coupled oscillator sync block.
// Used by the register file, the serial divider, the top level and the checker.
package pcos_pkg;

    localparam int TIME_WIDTH_DEFAULT  = 24;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int FILTER_SAMPLES      = 10;

    localparam int PERIOD_WIDTH     = 23;
    localparam int PEER_WIDTH       = 16;
    localparam int FILTER_SUM_WIDTH = 20;
    localparam logic [FILTER_SUM_WIDTH-1:0] FILTER_SUM_MAX = '1;

    localparam int NOMINAL_WIDTH  = 22;
    localparam int TOL_WIDTH      = 20;
    localparam int CORR_WIDTH     = 21;
    localparam int LED_DUR_WIDTH  = 22;
    localparam int PSD_WIDTH      = 8;
    localparam int PCD_WIDTH      = 8;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 22;
    localparam int IN_DATA_WIDTH   = 8;
    localparam int OUT_DATA_WIDTH  = 48;

    // Bit positions of the single-bit result fields in the output beat.
    localparam int OUT_LED_BIT   = 0;
    localparam int OUT_SEND_BIT  = 1;
    localparam int OUT_FLASH_BIT = 2;

    localparam int BASE_FLASH_PERIOD = 1000000;

    localparam logic [NOMINAL_WIDTH-1:0] NOMINAL_PERIOD_RESET =
        NOMINAL_WIDTH'(BASE_FLASH_PERIOD);
    localparam logic [TOL_WIDTH-1:0]     PERIOD_TOL_RESET =
        TOL_WIDTH'(BASE_FLASH_PERIOD / 10);
    localparam logic [CORR_WIDTH-1:0]    MAX_CORR_RESET =
        CORR_WIDTH'(BASE_FLASH_PERIOD / 5);
    localparam logic [LED_DUR_WIDTH-1:0] LED_DUR_RESET = LED_DUR_WIDTH'(70000);
    localparam logic [PSD_WIDTH-1:0]     PSD_RESET     = PSD_WIDTH'(10);
    localparam logic [PCD_WIDTH-1:0]     PCD_RESET     = PCD_WIDTH'(40);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_NOMINAL_PERIOD   = 3'd0,
        REG_PERIOD_WINDOW    = 3'd1,
        REG_CORR_LIMIT       = 3'd2,
        REG_LED_HOLD         = 3'd3,
        REG_PHASE_SHIFT_DIV  = 3'd4,
        REG_PERIOD_CHANGE_DIV = 3'd5
    } cfg_reg_index_t;

    typedef struct packed {
        logic [NOMINAL_WIDTH-1:0] nominal_period;
        logic [TOL_WIDTH-1:0]     period_window;
        logic [CORR_WIDTH-1:0]    corr_limit;
        logic [LED_DUR_WIDTH-1:0] led_hold;
        logic [PSD_WIDTH-1:0]     phase_shift_divisor;
        logic [PCD_WIDTH-1:0]     period_change_divisor;
    } cfg_regs_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[design/pcos_cfg_regs.sv]
// Configuration register file of the pulse-coupled oscillator sync block.
// Depends on pcos_pkg for register indexes, widths and reset values.
module pcos_cfg_regs
    import pcos_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_regs_t                  regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NOMINAL_PERIOD:
                    regs_next.nominal_period = cfg_data[NOMINAL_WIDTH-1:0];
                REG_PERIOD_WINDOW:
                    regs_next.period_window = cfg_data[TOL_WIDTH-1:0];
                REG_CORR_LIMIT:
                    regs_next.corr_limit = cfg_data[CORR_WIDTH-1:0];
                REG_LED_HOLD:
                    regs_next.led_hold = cfg_data[LED_DUR_WIDTH-1:0];
                REG_PHASE_SHIFT_DIV:
                    regs_next.phase_shift_divisor = cfg_data[PSD_WIDTH-1:0];
                REG_PERIOD_CHANGE_DIV:
                    regs_next.period_change_divisor = cfg_data[PCD_WIDTH-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.nominal_period        <= NOMINAL_PERIOD_RESET;
            regs_reg.period_window         <= PERIOD_TOL_RESET;
            regs_reg.corr_limit            <= MAX_CORR_RESET;
            regs_reg.led_hold              <= LED_DUR_RESET;
            regs_reg.phase_shift_divisor   <= PSD_RESET;
            regs_reg.period_change_divisor <= PCD_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[design/pcos_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on pcos_pkg for the status struct.
module pcos_serial_div
    import pcos_pkg::*;
#(
    parameter int DVD_W = 25,
    parameter int DVS_W = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W-1:0] dq_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;
    logic [DVD_W-1:0] dq_next;
    logic [DVS_W-1:0] rem_next;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[DVD_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dq_next  = {dq_reg[DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = dq_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[design/pulse_coupled_oscillator_sync.sv]
// Top level of the pulse-coupled oscillator sync block: sequencer and datapath.
// Depends on pcos_pkg, pcos_cfg_regs and pcos_serial_div.
//
// Each input beat is one microsecond tick and carries pulse_seen, a flag that a
// peer flash pulse was heard during that tick; each tick yields exactly one
// output beat with the LED state, the send-pulse and flash-start flags, the
// adapted period and the filtered peer count. The phase counter advances once
// per tick; a heard pulse is echoed at once and its early or late timing error
// is weakened by phase_shift_divisor and the filtered peer count, clamped to
// the correction limit, taken off the phase and passed in part to the period,
// which stays within nominal_period plus or minus the period window. When the
// phase passes the period with the LED dark, the block flashes, restarts the
// phase, sends its own pulse and refreshes the peer filter; the LED goes dark
// once the phase passes the LED hold time. All three divisions run one bit per
// cycle through a single shared restoring divider with a MAG-bit dividend,
// where MAG is max(TIME_WIDTH, 23) + 1 (25 at the default widths). A tick
// without a pulse or a flash passes through the idle, flash-check and output
// states; a pulse adds a setup state and two divider passes and a flash adds
// one pass, and the output state waits while the output side stalls. One tick
// is processed at a time; its finished beat waits in an output register, so
// the next tick is accepted while that beat has not yet been taken.
// Configuration writes are always accepted and should be made only while no
// tick is in flight.
module pulse_coupled_oscillator_sync
    import pcos_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Bits from the lowest up: pulse_seen (1), zero fill (7).
    input  logic [IN_DATA_WIDTH-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Bits from the lowest up: led_lit (1), send_pulse (1), flash_start (1),
    // current_period (23), peer_estimate (16), zero fill (6).
    output logic [OUT_DATA_WIDTH-1:0]  m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int ERR_W = ((TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH) + 2;
    localparam int MAG_W = ERR_W - 1;
    localparam int DVS_W = PSD_WIDTH + COUNT_WIDTH;
    localparam int PA_W  = PERIOD_WIDTH + 2;
    localparam int SUM_W = ((FILTER_SUM_WIDTH > COUNT_WIDTH) ? FILTER_SUM_WIDTH
                                                             : COUNT_WIDTH) + 1;
    localparam int QB_W  = (MAG_W > COUNT_WIDTH) ? MAG_W : COUNT_WIDTH;

    localparam logic signed [TIME_WIDTH-1:0] PH_TOP = {1'b0, {(TIME_WIDTH-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] PH_MAX = signed'(ERR_W'(PH_TOP));
    localparam logic signed [ERR_W-1:0] PH_MIN = ~PH_MAX;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULSE,
        S_DIV_ERR,
        S_DIV_PER,
        S_FLASH,
        S_DIV_FILT,
        S_OUT
    } state_t;

    cfg_regs_t   cfg;
    div_status_t div_status;
    logic [MAG_W-1:0] div_quotient;

    logic             div_go;
    logic             div_start;
    logic [MAG_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;

    state_t                        state_reg, state_next;
    logic signed [TIME_WIDTH-1:0]  phase_reg, phase_next;
    logic [PERIOD_WIDTH-1:0]       adapted_reg, adapted_next;
    logic                          led_reg, led_next;
    logic [COUNT_WIDTH-1:0]        pulses_reg, pulses_next;
    logic [FILTER_SUM_WIDTH-1:0]   fsum_reg, fsum_next;
    logic [COUNT_WIDTH-1:0]        fpeers_reg, fpeers_next;
    logic                          err_neg_reg, err_neg_next;
    logic [CORR_WIDTH-1:0]         corr_reg, corr_next;
    logic                          send_reg, send_next;
    logic                          flash_reg, flash_next;
    logic                          out_valid_reg, out_valid_next;
    logic [OUT_DATA_WIDTH-1:0]     out_data_reg, out_data_next;

    logic                          in_beat;
    logic signed [TIME_WIDTH-1:0]  phase_inc;
    logic signed [ERR_W-1:0]       phase_ext;
    logic signed [ERR_W-1:0]       per_ext;
    logic signed [ERR_W-1:0]       half_ext;
    logic signed [ERR_W-1:0]       dur_ext;
    logic                          early;
    logic signed [ERR_W-1:0]       err_c;
    logic signed [ERR_W-1:0]       err_negated;
    logic [MAG_W-1:0]              err_mag;
    logic [PSD_WIDTH-1:0]          psd_eff;
    logic [PCD_WIDTH-1:0]          pcd_eff;
    logic [COUNT_WIDTH-1:0]        fpeers_eff;
    logic [DVS_W-1:0]              err_divisor;
    logic [CORR_WIDTH-1:0]         corr_c;
    logic signed [ERR_W-1:0]       corr_ext;
    logic signed [ERR_W-1:0]       ph_adj;
    logic signed [TIME_WIDTH-1:0]  phase_sat;
    logic signed [PA_W-1:0]        per_s;
    logic signed [PA_W-1:0]        step_s;
    logic signed [PA_W-1:0]        p_c;
    logic signed [PA_W-1:0]        lo_s;
    logic signed [PA_W-1:0]        hi_s;
    logic signed [PA_W-1:0]        p_clamped;
    logic                          flash_cond;
    logic [SUM_W-1:0]              sum_c;
    logic [FILTER_SUM_WIDTH-1:0]   sum_sat;
    logic [QB_W-1:0]               q_big;
    logic [COUNT_WIDTH-1:0]        fpeers_sat;
    logic                          out_load;

    pcos_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    pcos_serial_div #(
        .DVD_W (MAG_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign div_start     = div_go && !div_status.busy;

    // Datapath terms shared by several states.
    always_comb
    begin
        phase_inc = (phase_reg == PH_TOP) ? phase_reg : phase_reg + 1'b1;

        phase_ext = ERR_W'(phase_reg);
        per_ext   = signed'(ERR_W'(adapted_reg));
        half_ext  = signed'(ERR_W'(adapted_reg >> 1));
        dur_ext   = signed'(ERR_W'(cfg.led_hold));

        // Early when the phase lies in the first half of the period, else late.
        early       = !phase_reg[TIME_WIDTH-1] && (phase_ext < half_ext);
        err_c       = early ? phase_ext : phase_ext - per_ext;
        err_negated = -err_c;
        err_mag     = err_c[ERR_W-1] ? MAG_W'(err_negated) : MAG_W'(err_c);

        psd_eff     = (cfg.phase_shift_divisor == '0) ? PSD_WIDTH'(1)
                                                      : cfg.phase_shift_divisor;
        pcd_eff     = (cfg.period_change_divisor == '0) ? PCD_WIDTH'(1)
                                                        : cfg.period_change_divisor;
        fpeers_eff  = (fpeers_reg == '0) ? COUNT_WIDTH'(1) : fpeers_reg;
        // Two truncating divisions in a row equal one by the product.
        err_divisor = DVS_W'(psd_eff) * DVS_W'(fpeers_eff);

        corr_c = (div_quotient > MAG_W'(cfg.corr_limit))
                 ? cfg.corr_limit : div_quotient[CORR_WIDTH-1:0];

        corr_ext = signed'(ERR_W'(corr_reg));
        ph_adj   = err_neg_reg ? phase_ext + corr_ext : phase_ext - corr_ext;
        if (ph_adj > PH_MAX)
            phase_sat = PH_TOP;
        else if (ph_adj < PH_MIN)
            phase_sat = ~PH_TOP;
        else
            phase_sat = ph_adj[TIME_WIDTH-1:0];

        per_s  = signed'(PA_W'(adapted_reg));
        step_s = signed'(PA_W'(div_quotient[CORR_WIDTH-1:0]));
        p_c    = err_neg_reg ? per_s - step_s : per_s + step_s;
        lo_s   = signed'(PA_W'(cfg.nominal_period)) - signed'(PA_W'(cfg.period_window));
        if (lo_s[PA_W-1])
            lo_s = '0;
        hi_s   = signed'(PA_W'(cfg.nominal_period)) + signed'(PA_W'(cfg.period_window));
        if (p_c < lo_s)
            p_clamped = lo_s;
        else if (p_c > hi_s)
            p_clamped = hi_s;
        else
            p_clamped = p_c;

        // A negative phase never exceeds a non-negative limit, as the rule of
        // treating it as zero requires.
        flash_cond = !led_reg && (phase_ext > per_ext);

        sum_c   = SUM_W'(fsum_reg) + SUM_W'(pulses_reg) - SUM_W'(fpeers_reg);
        sum_sat = (sum_c > SUM_W'(FILTER_SUM_MAX)) ? FILTER_SUM_MAX
                                                  : sum_c[FILTER_SUM_WIDTH-1:0];

        q_big      = QB_W'(div_quotient);
        fpeers_sat = (q_big > QB_W'(CNT_MAX)) ? CNT_MAX : q_big[COUNT_WIDTH-1:0];

        out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        adapted_next   = adapted_reg;
        led_next       = led_reg;
        pulses_next    = pulses_reg;
        fsum_next      = fsum_reg;
        fpeers_next    = fpeers_reg;
        err_neg_next   = err_neg_reg;
        corr_next      = corr_reg;
        send_next      = send_reg;
        flash_next     = flash_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        div_go         = 1'b0;
        div_dividend   = err_mag;
        div_divisor    = err_divisor;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    phase_next = phase_inc;
                    send_next  = s_axis_tdata[0];
                    flash_next = 1'b0;
                    state_next = s_axis_tdata[0] ? S_PULSE : S_FLASH;
                end
            end
            S_PULSE:
            begin
                err_neg_next = err_c[ERR_W-1];
                if (pulses_reg != CNT_MAX)
                    pulses_next = pulses_reg + 1'b1;
                div_go       = 1'b1;
                div_dividend = err_mag;
                div_divisor  = err_divisor;
                state_next   = S_DIV_ERR;
            end
            S_DIV_ERR:
            begin
                if (div_status.done)
                begin
                    corr_next    = corr_c;
                    div_go       = 1'b1;
                    div_dividend = MAG_W'(corr_c);
                    div_divisor  = DVS_W'(pcd_eff);
                    state_next   = S_DIV_PER;
                end
            end
            S_DIV_PER:
            begin
                if (div_status.done)
                begin
                    phase_next   = phase_sat;
                    adapted_next = p_clamped[PERIOD_WIDTH-1:0];
                    state_next   = S_FLASH;
                end
            end
            S_FLASH:
            begin
                if (flash_cond)
                begin
                    led_next     = 1'b1;
                    phase_next   = '0;
                    send_next    = 1'b1;
                    flash_next   = 1'b1;
                    fsum_next    = sum_sat;
                    pulses_next  = '0;
                    div_go       = 1'b1;
                    div_dividend = MAG_W'(sum_sat);
                    div_divisor  = DVS_W'(FILTER_SAMPLES);
                    state_next   = S_DIV_FILT;
                end
                else
                begin
                    if (led_reg && (phase_ext > dur_ext))
                        led_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_DIV_FILT:
            begin
                if (div_status.done)
                begin
                    fpeers_next = fpeers_sat;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_DATA_WIDTH'({PEER_WIDTH'(fpeers_reg), adapted_reg,
                                                      flash_reg, send_reg, led_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            adapted_reg   <= PERIOD_WIDTH'(NOMINAL_PERIOD_RESET);
            led_reg       <= 1'b0;
            pulses_reg    <= '0;
            fsum_reg      <= '0;
            fpeers_reg    <= '0;
            err_neg_reg   <= 1'b0;
            corr_reg      <= '0;
            send_reg      <= 1'b0;
            flash_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            adapted_reg   <= adapted_next;
            led_reg       <= led_next;
            pulses_reg    <= pulses_next;
            fsum_reg      <= fsum_next;
            fpeers_reg    <= fpeers_next;
            err_neg_reg   <= err_neg_next;
            corr_reg      <= corr_next;
            send_reg      <= send_next;
            flash_reg     <= flash_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

[design/pcos_checker.sv]
// Port-level checker for the pulse-coupled oscillator sync block, with its bind.
// Depends on pcos_pkg and the assertion macro header.
`include "pulse_coupled_oscillator_sync_macros.svh"

module pcos_checker
    import pcos_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

    // A flash lights the LED and broadcasts a pulse in the same tick.
    `PCOS_ASSERT_IMP(a_flash_lit, clk, rst_n, m_axis_tvalid && m_axis_tdata[OUT_FLASH_BIT], m_axis_tdata[OUT_SEND_BIT] && m_axis_tdata[OUT_LED_BIT], "flash beat without LED lit and pulse sent")

    // One tick at a time: the beat after an accepted one is never taken at once.
    `PCOS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted on back-to-back cycles")

    // A stalled output beat holds.
    `PCOS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")

endmodule

bind pulse_coupled_oscillator_sync pcos_checker u_checker (.*);
